### hw/rtl/madf_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// madf_pkg: shared types for the mac allow/deny filter table
// Operation codes, filter modes, status codes and the token that walks the
// cell chain.
// ----------------------------------------------------------------------------
package madf_pkg;

	localparam int MAC_W = 48;

	typedef enum logic [1:0] {
		FUNC_CHECK  = 2'd0,
		FUNC_ADD    = 2'd1,
		FUNC_DELETE = 2'd2,
		FUNC_CLEAR  = 2'd3
	} func_t;

	typedef enum logic [1:0] {
		MODE_OFF   = 2'd0,
		MODE_DENY  = 2'd1,
		MODE_ALLOW = 2'd2,
		MODE_SPARE = 2'd3
	} mode_t;

	typedef enum logic [1:0] {
		STATUS_OK        = 2'd0,
		STATUS_NOT_FOUND = 2'd1,
		STATUS_FULL      = 2'd2,
		STATUS_SPARE     = 2'd3
	} status_t;

	// one operation in flight; done is set once a cell has served it (never for clear)
	typedef struct packed {
		logic              vld;
		func_t             func;
		logic [MAC_W-1:0]  addr;
		logic              done;
	} token_t;

endpackage

### hw/rtl/madf_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// madf_cell: one cell of the filter table chain
// Holds SLOTS table slots, serves the passing operation against them and
// hands the token on to the next cell through its token register.
// ----------------------------------------------------------------------------
module madf_cell #(
	parameter int SLOTS = 8
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             en,
	input  madf_pkg::token_t tok_in,
	output madf_pkg::token_t tok_out
);

	logic [SLOTS-1:0]           valid_q;
	logic [madf_pkg::MAC_W-1:0] addr_q [SLOTS];
	madf_pkg::token_t           tok_q;

	logic [SLOTS-1:0] hit_vec;
	logic [SLOTS-1:0] hit_first;
	logic [SLOTS-1:0] free_vec;
	logic [SLOTS-1:0] free_first;
	logic [SLOTS-1:0] valid_nxt;
	logic             done_nxt;
	logic             take;
	logic             add_here;
	madf_pkg::token_t tok_nxt;

	always_comb begin
		for (int j = 0; j < SLOTS; j++) begin
			hit_vec[j] = valid_q[j] && (addr_q[j] == tok_in.addr);
		end
	end

	// isolate lowest set bit
	assign hit_first  = hit_vec & (~hit_vec + SLOTS'(1));
	assign free_vec   = ~valid_q;
	assign free_first = free_vec & (~free_vec + SLOTS'(1));

	assign take     = en && tok_in.vld;
	assign add_here = (tok_in.func == madf_pkg::FUNC_ADD) && !tok_in.done;

	always_comb begin
		valid_nxt = valid_q;
		done_nxt  = tok_in.done;
		case (tok_in.func)
			madf_pkg::FUNC_CHECK: begin
				done_nxt = tok_in.done || (|hit_vec);
			end
			madf_pkg::FUNC_ADD: begin
				if (!tok_in.done) begin
					valid_nxt = valid_q | free_first;
				end
				done_nxt = tok_in.done || (|free_vec);
			end
			madf_pkg::FUNC_DELETE: begin
				if (!tok_in.done) begin
					valid_nxt = valid_q & ~hit_first;
				end
				done_nxt = tok_in.done || (|hit_vec);
			end
			madf_pkg::FUNC_CLEAR: begin
				valid_nxt = '0;
			end
			default: begin
				valid_nxt = valid_q;
			end
		endcase
	end

	always_comb begin
		tok_nxt      = tok_in;
		tok_nxt.done = done_nxt;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
		end else if (take) begin
			valid_q <= valid_nxt;
		end
	end

	always_ff @(posedge clk) begin
		for (int j = 0; j < SLOTS; j++) begin
			if (take && add_here && free_first[j]) begin
				addr_q[j] <= tok_in.addr;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tok_q <= '0;
		end else if (en) begin
			tok_q <= tok_nxt;
		end
	end

	assign tok_out = tok_q;

endmodule

### hw/rtl/mac_allow_deny_filter_table.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mac_allow_deny_filter_table: mac address allow/deny list filter
// Table of mac addresses with check, add, delete and clear operations.
// ----------------------------------------------------------------------------
// The table is split over a chain of cells of CELL_ENTRIES slots each, the
// last cell holding the rest, and an operation walks the chain one cell per
// cycle unless the chain holds; a result passes through each cell's token
// register and then the output register. Operations follow each other
// through the chain, so one transfer per cycle is taken while the output side
// keeps up, and the whole chain holds while a result waits. Lowest-slot order
// for add and delete comes from each cell serving the token only if no
// earlier cell did. The table is empty after reset with no clearing pass.
module mac_allow_deny_filter_table #(
	parameter int TABLE_ENTRIES = 64,
	parameter int CELL_ENTRIES  = 8
) (
	input  logic        clk,
	input  logic        arst_n,
	// config
	input  logic        cfg_we,
	input  logic [1:0]  cfg_wdata,     // filter_mode
	// operation in
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [47:0] s_axis_tdata,  // mac_addr[47:0]
	input  logic [1:0]  s_axis_tuser,  // func[1:0]
	// result out
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [7:0]  m_axis_tdata   // reject[0], status[2:1], zero[7:3]
);

	localparam int NUM_CELLS = (TABLE_ENTRIES + CELL_ENTRIES - 1) / CELL_ENTRIES;
	localparam int LAST_SLOTS = TABLE_ENTRIES - CELL_ENTRIES * (NUM_CELLS - 1);

	madf_pkg::token_t  tok [NUM_CELLS + 1];
	madf_pkg::mode_t   mode_q;
	logic              out_vld_q;
	logic              reject_q;
	madf_pkg::status_t status_q;
	logic              en;
	logic              reject_nxt;
	madf_pkg::status_t status_nxt;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= madf_pkg::MODE_OFF;
		end else if (cfg_we) begin
			mode_q <= madf_pkg::mode_t'(cfg_wdata);
		end
	end

	// chain moves whenever the output register can take what falls out
	assign en = !out_vld_q || m_axis_tready;
	assign s_axis_tready = en;

	assign tok[0] = '{
		vld:  s_axis_tvalid,
		func: madf_pkg::func_t'(s_axis_tuser),
		addr: s_axis_tdata,
		done: 1'b0
	};

	for (genvar i = 0; i < NUM_CELLS; i++) begin : g_cell
		localparam int SLOTS = (i == NUM_CELLS - 1) ? LAST_SLOTS : CELL_ENTRIES;
		madf_cell #(
			.SLOTS(SLOTS)
		) u_cell (
			.clk    (clk),
			.arst_n (arst_n),
			.en     (en),
			.tok_in (tok[i]),
			.tok_out(tok[i+1])
		);
	end

	always_comb begin
		reject_nxt = 1'b0;
		status_nxt = madf_pkg::STATUS_OK;
		case (tok[NUM_CELLS].func)
			madf_pkg::FUNC_CHECK: begin
				if (mode_q == madf_pkg::MODE_DENY) begin
					reject_nxt = tok[NUM_CELLS].done;
				end else if (mode_q == madf_pkg::MODE_ALLOW) begin
					reject_nxt = !tok[NUM_CELLS].done;
				end
			end
			madf_pkg::FUNC_ADD: begin
				if (!tok[NUM_CELLS].done) begin
					status_nxt = madf_pkg::STATUS_FULL;
				end
			end
			madf_pkg::FUNC_DELETE: begin
				if (!tok[NUM_CELLS].done) begin
					status_nxt = madf_pkg::STATUS_NOT_FOUND;
				end
			end
			default: begin
				status_nxt = madf_pkg::STATUS_OK;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
		end else if (en) begin
			out_vld_q <= tok[NUM_CELLS].vld;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			reject_q <= reject_nxt;
			status_q <= status_nxt;
		end
	end

	assign m_axis_tvalid = out_vld_q;
	assign m_axis_tdata  = {5'd0, status_q, reject_q};

	// a rejected check always carries ok status
	a_reject_ok: assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && m_axis_tdata[0]) |-> (m_axis_tdata[2:1] == madf_pkg::STATUS_OK))
		else $error("reject with non-ok status");

	// nothing is rejected while the filter is off
	a_reject_mode: assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && m_axis_tdata[0]) |->
			(mode_q == madf_pkg::MODE_DENY || mode_q == madf_pkg::MODE_ALLOW))
		else $error("reject with filter disabled");

	// the unused status code never leaves the block
	a_status_code: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> (m_axis_tdata[2:1] != madf_pkg::STATUS_SPARE))
		else $error("unused status code");

endmodule

### sim/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top: testbench for mac_allow_deny_filter_table
// Drives check, add, delete and clear operations over the stream input, keeps
// its own copy of the address table and filter mode, and compares every result
// transfer field by field with the predicted reject flag and status. Runs a
// directed pass, a table-full pass and random passes in each filter mode;
// both sides stall at random but for the last round of random passes.
// ----------------------------------------------------------------------------
module tb_top;

	localparam int TABLE_SIZE = 64;
	localparam int POOL_SIZE  = 16;
	localparam logic [47:0] MAC_ALL_ONES = 48'hffff_ffff_ffff;

	typedef struct packed {
		logic              reject;
		madf_pkg::status_t status;
	} verdict_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        cfg_we = 1'b0;
	logic [1:0]  cfg_wdata = madf_pkg::MODE_OFF;
	logic        s_axis_tvalid = 1'b0;
	logic        s_axis_tready;
	logic [47:0] s_axis_tdata = '0;    // mac_addr[47:0]
	logic [1:0]  s_axis_tuser = madf_pkg::FUNC_CHECK;  // func[1:0]
	logic        m_axis_tvalid;
	logic        m_axis_tready = 1'b0;
	logic [7:0]  m_axis_tdata;         // reject[0], status[2:1], zero[7:3]

	// filter state as the block should hold it
	logic [47:0]     table_addr [TABLE_SIZE];
	logic            table_used [TABLE_SIZE];
	madf_pkg::mode_t cur_mode = madf_pkg::MODE_OFF;

	verdict_t    pending_verdicts[$];
	logic [47:0] mac_pool [POOL_SIZE];
	int          send_idle_pct = 10;
	int          recv_idle_pct = 54;
	int          errors = 0;

	mac_allow_deny_filter_table #(
		.TABLE_ENTRIES(TABLE_SIZE)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_wdata(cfg_wdata),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata),
		.s_axis_tuser(s_axis_tuser),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata)
	);

	always #5 clk = ~clk;

	function automatic logic [47:0] rand_mac();
		logic [63:0] w;
		w = {$urandom(), $urandom()};
		return w[47:0];
	endfunction

	function automatic int lowest_match(input logic [47:0] a);
		for (int i = 0; i < TABLE_SIZE; i++) begin
			if (table_used[i] && table_addr[i] == a)
				return i;
		end
		return TABLE_SIZE;
	endfunction

	function automatic int lowest_free();
		for (int i = 0; i < TABLE_SIZE; i++) begin
			if (!table_used[i])
				return i;
		end
		return TABLE_SIZE;
	endfunction

	task automatic predict_filter_op(input madf_pkg::func_t f, input logic [47:0] a);
		verdict_t v;
		int slot;
		v.reject = 1'b0;
		v.status = madf_pkg::STATUS_OK;
		case (f)
			madf_pkg::FUNC_CHECK: begin
				// spare mode code acts as disabled
				if (cur_mode == madf_pkg::MODE_DENY)
					v.reject = (lowest_match(a) < TABLE_SIZE);
				else if (cur_mode == madf_pkg::MODE_ALLOW)
					v.reject = (lowest_match(a) == TABLE_SIZE);
			end
			madf_pkg::FUNC_ADD: begin
				slot = lowest_free();
				if (slot < TABLE_SIZE) begin
					table_addr[slot] = a;
					table_used[slot] = 1'b1;
				end else begin
					v.status = madf_pkg::STATUS_FULL;
				end
			end
			madf_pkg::FUNC_DELETE: begin
				slot = lowest_match(a);
				if (slot < TABLE_SIZE)
					table_used[slot] = 1'b0;
				else
					v.status = madf_pkg::STATUS_NOT_FOUND;
			end
			default: begin
				for (int i = 0; i < TABLE_SIZE; i++)
					table_used[i] = 1'b0;
			end
		endcase
		pending_verdicts.push_back(v);
	endtask

	// valid stays high from one transfer to the next unless a gap is taken
	task automatic send_op(input madf_pkg::func_t f, input logic [47:0] a);
		if ($urandom_range(99) < send_idle_pct) begin
			s_axis_tvalid <= 1'b0;
			@(posedge clk);
			while ($urandom_range(99) < send_idle_pct)
				@(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= a;
		s_axis_tuser  <= f;
		do
			@(posedge clk);
		while (!s_axis_tready);
		predict_filter_op(f, a);
	endtask

	task automatic wait_idle();
		s_axis_tvalid <= 1'b0;
		do
			@(posedge clk);
		while (pending_verdicts.size() != 0);
	endtask

	task automatic set_mode(input madf_pkg::mode_t m);
		wait_idle();
		cfg_we    <= 1'b1;
		cfg_wdata <= m;
		@(posedge clk);
		cfg_we    <= 1'b0;
		cur_mode = m;
	endtask

	task automatic test_directed_ops();
		send_op(madf_pkg::FUNC_CHECK, 48'h0);
		send_op(madf_pkg::FUNC_ADD, 48'h0);
		send_op(madf_pkg::FUNC_ADD, MAC_ALL_ONES);
		send_op(madf_pkg::FUNC_ADD, 48'h0);           // duplicate entry
		send_op(madf_pkg::FUNC_CHECK, MAC_ALL_ONES);  // disabled, never rejects
		set_mode(madf_pkg::MODE_DENY);
		send_op(madf_pkg::FUNC_CHECK, 48'h0);
		send_op(madf_pkg::FUNC_CHECK, 48'h1234_5678_9abc);
		set_mode(madf_pkg::MODE_ALLOW);
		send_op(madf_pkg::FUNC_CHECK, MAC_ALL_ONES);
		send_op(madf_pkg::FUNC_CHECK, 48'h1);
		send_op(madf_pkg::FUNC_DELETE, 48'h0);        // lowest copy goes, one stays
		send_op(madf_pkg::FUNC_CHECK, 48'h0);
		send_op(madf_pkg::FUNC_DELETE, 48'h0);
		send_op(madf_pkg::FUNC_DELETE, 48'h0);        // nothing left to delete
		send_op(madf_pkg::FUNC_CHECK, 48'h0);
		set_mode(madf_pkg::MODE_SPARE);
		send_op(madf_pkg::FUNC_CHECK, 48'h1);
		send_op(madf_pkg::FUNC_CLEAR, MAC_ALL_ONES);
		send_op(madf_pkg::FUNC_DELETE, MAC_ALL_ONES);
		set_mode(madf_pkg::MODE_ALLOW);
		send_op(madf_pkg::FUNC_CHECK, MAC_ALL_ONES);
	endtask

	task automatic test_table_full();
		logic [47:0] kept [TABLE_SIZE];
		set_mode(madf_pkg::MODE_DENY);
		send_op(madf_pkg::FUNC_CLEAR, rand_mac());
		for (int i = 0; i < TABLE_SIZE; i++) begin
			if ($urandom_range(3) == 0)
				kept[i] = mac_pool[$urandom_range(POOL_SIZE - 1)];
			else
				kept[i] = rand_mac();
			send_op(madf_pkg::FUNC_ADD, kept[i]);
		end
		send_op(madf_pkg::FUNC_ADD, rand_mac());
		send_op(madf_pkg::FUNC_CHECK, kept[TABLE_SIZE - 1]);
		send_op(madf_pkg::FUNC_DELETE, kept[$urandom_range(TABLE_SIZE - 1)]);
		send_op(madf_pkg::FUNC_ADD, rand_mac());      // takes the freed slot
		send_op(madf_pkg::FUNC_ADD, MAC_ALL_ONES);
		send_op(madf_pkg::FUNC_CHECK, kept[0]);
	endtask

	// pool addresses keep hits and successful deletes frequent
	task automatic test_random_ops(input int n);
		madf_pkg::func_t f;
		logic [47:0] a;
		int r;
		for (int i = 0; i < n; i++) begin
			r = $urandom_range(99);
			if (r < 40)
				f = madf_pkg::FUNC_CHECK;
			else if (r < 70)
				f = madf_pkg::FUNC_ADD;
			else if (r < 97)
				f = madf_pkg::FUNC_DELETE;
			else
				f = madf_pkg::FUNC_CLEAR;
			if ($urandom_range(99) < 75)
				a = mac_pool[$urandom_range(POOL_SIZE - 1)];
			else
				a = rand_mac();
			send_op(f, a);
		end
	endtask

	always @(posedge clk) begin : result_check
		verdict_t want;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			if (pending_verdicts.size() == 0) begin
				$display("%0t: unexpected result transfer, expected none, actual %h",
					$time, m_axis_tdata);
				errors++;
			end else begin
				want = pending_verdicts.pop_front();
				if (m_axis_tdata[0] !== want.reject) begin
					$display("%0t: reject mismatch, expected %0d, actual %0d",
						$time, want.reject, m_axis_tdata[0]);
					errors++;
				end
				if (m_axis_tdata[2:1] !== want.status) begin
					$display("%0t: status mismatch, expected %0d, actual %0d",
						$time, want.status, m_axis_tdata[2:1]);
					errors++;
				end
			end
		end
		m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
	end

	initial begin
		#5_000_000;
		$display("RESULT: ERROR");
		$finish;
	end

	initial begin
		madf_pkg::mode_t mode_seq [4];
		int idle_send [3];
		int idle_recv [3];
		mode_seq  = '{madf_pkg::MODE_OFF, madf_pkg::MODE_DENY, madf_pkg::MODE_ALLOW,
			madf_pkg::MODE_SPARE};
		idle_send = '{10, 54, 0};
		idle_recv = '{54, 10, 0};
		for (int i = 0; i < TABLE_SIZE; i++) begin
			table_addr[i] = '0;
			table_used[i] = 1'b0;
		end
		mac_pool[0] = 48'h0;
		mac_pool[1] = MAC_ALL_ONES;
		for (int i = 2; i < POOL_SIZE; i++)
			mac_pool[i] = rand_mac();

		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_directed_ops();
		test_table_full();
		for (int p = 0; p < 3; p++) begin
			send_idle_pct = idle_send[p];
			recv_idle_pct = idle_recv[p];
			for (int m = 0; m < 4; m++) begin
				set_mode(mode_seq[m]);
				test_random_ops(155);
			end
		end

		wait_idle();
		// catch any stray result after the last one
		repeat (20) @(posedge clk);
		if (errors == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

endmodule
